>>> sv/cubic_bezier_subdivider_assert.svh
// assertion macros for the cubic bezier subdivider checker
// no dependencies
`ifndef CUBIC_BEZIER_SUBDIVIDER_ASSERT_SVH
`define CUBIC_BEZIER_SUBDIVIDER_ASSERT_SVH
// same-cycle implication under reset
`define CBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cbs assertion failed");
// next-cycle implication under reset
`define CBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cbs assertion failed");
`endif

>>> sv/cbs_pkg.sv
// shared types, constants and midpoint functions for the bezier subdivider
// no dependencies
package cbs_pkg;
    localparam int MAX_LEVEL   = 6;
    localparam int COORD_WIDTH = 32;
    localparam int LEVEL_WIDTH = 3;
    localparam logic [LEVEL_WIDTH-1:0] LEVEL_RESET = 3'd4;
    localparam logic [2:0] ADDR_LEVEL = 3'd0;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef struct packed {
        t_point p0;
        t_point p1;
        t_point p2;
        t_point p3;
    } t_curve;

    // one curve request travelling between neighbor cells
    typedef struct packed {
        logic   valid;
        logic   last;
        t_curve curve;
    } t_flow;

    // floor((a + b) / 2) without overflow
    function automatic t_coord half_sum(t_coord a, t_coord b);
        logic signed [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        return s[COORD_WIDTH:1];
    endfunction

    function automatic t_point mid3(t_point a, t_point b);
        t_point r;
        r.x = half_sum(a.x, b.x);
        r.y = half_sum(a.y, b.y);
        r.z = half_sum(a.z, b.z);
        return r;
    endfunction
endpackage

>>> sv/cbs_cell.sv
// one subdivision cell: splits a curve into halves, sends left then right, or passes it on whole when bypassed
// depends on cbs_pkg
module cbs_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_bypass,
    input  cbs_pkg::t_flow i_flow,
    output logic          o_ready,
    output cbs_pkg::t_flow o_flow,
    input  logic          i_ready,
    output logic          o_active
);
    logic            r_valid, n_valid;
    logic            r_last, n_last;
    cbs_pkg::t_curve r_curve, n_curve;
    logic            r_pend, n_pend;
    logic            r_rlast, n_rlast;
    cbs_pkg::t_curve r_right, n_right;
    cbs_pkg::t_curve left_c, right_c;
    cbs_pkg::t_point m01, m12, m23, m012, m123, mid;
    logic            out_free;

    // de casteljau split of the incoming curve
    always_comb begin
        m01  = cbs_pkg::mid3(i_flow.curve.p0, i_flow.curve.p1);
        m12  = cbs_pkg::mid3(i_flow.curve.p1, i_flow.curve.p2);
        m23  = cbs_pkg::mid3(i_flow.curve.p2, i_flow.curve.p3);
        m012 = cbs_pkg::mid3(m01, m12);
        m123 = cbs_pkg::mid3(m12, m23);
        mid  = cbs_pkg::mid3(m012, m123);
        left_c  = '{p0: i_flow.curve.p0, p1: m01, p2: m012, p3: mid};
        right_c = '{p0: mid, p1: m123, p2: m23, p3: i_flow.curve.p3};
    end

    assign out_free = !r_valid || i_ready;
    assign o_ready  = !r_pend && out_free;
    assign o_active = r_valid || r_pend;
    assign o_flow   = '{valid: r_valid, last: r_last, curve: r_curve};

    // output register and pending right half
    always_comb begin
        n_valid = r_valid && !i_ready;
        n_last  = r_last;
        n_curve = r_curve;
        n_pend  = r_pend;
        n_rlast = r_rlast;
        n_right = r_right;
        if (out_free && r_pend) begin
            n_valid = 1'b1;
            n_last  = r_rlast;
            n_curve = r_right;
            n_pend  = 1'b0;
        end else if (out_free && i_flow.valid) begin
            n_valid = 1'b1;
            if (i_bypass) begin
                n_last  = i_flow.last;
                n_curve = i_flow.curve;
            end else begin
                n_last  = 1'b0;
                n_curve = left_c;
                n_pend  = 1'b1;
                n_rlast = i_flow.last;
                n_right = right_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
        r_last  <= n_last;
        r_curve <= n_curve;
        r_rlast <= n_rlast;
        r_right <= n_right;
    end
endmodule

>>> sv/cubic_bezier_subdivider.sv
// top level: config register, chain of subdivision cells, segment output
// depends on cbs_pkg and cbs_cell
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------
//  curve in  | start & !busy                | i_start_*, i_near_*, i_end_*
//  segment   | o_seg_valid, one cycle       | o_seg_*, o_last_segment
//  config    | psel & penable & pwrite      | paddr, pwdata, prdata
//
// a curve at level L gives 2^L segments (levels above 6 act as 6); the first one
// leaves the chain of six cells through the output register of every cell, then
// one segment follows every cycle. busy stays high until the cycle after the last
// segment, so a new request is taken only once the last one has left the chain.
// reset clears the chain and sets the level to 4. the receiver cannot stall.
module cubic_bezier_subdivider (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   i_start_x,
    input  logic signed [31:0]   i_start_y,
    input  logic signed [31:0]   i_start_z,
    input  logic signed [31:0]   i_near_start_x,
    input  logic signed [31:0]   i_near_start_y,
    input  logic signed [31:0]   i_near_start_z,
    input  logic signed [31:0]   i_near_end_x,
    input  logic signed [31:0]   i_near_end_y,
    input  logic signed [31:0]   i_near_end_z,
    input  logic signed [31:0]   i_end_x,
    input  logic signed [31:0]   i_end_y,
    input  logic signed [31:0]   i_end_z,
    output logic                 o_seg_valid,
    output logic signed [31:0]   o_seg_start_x,
    output logic signed [31:0]   o_seg_start_y,
    output logic signed [31:0]   o_seg_start_z,
    output logic signed [31:0]   o_seg_end_x,
    output logic signed [31:0]   o_seg_end_y,
    output logic signed [31:0]   o_seg_end_z,
    output logic                 o_last_segment
);
    logic [cbs_pkg::LEVEL_WIDTH-1:0] r_level;
    logic [cbs_pkg::LEVEL_WIDTH-1:0] lvl;
    cbs_pkg::t_flow flow  [cbs_pkg::MAX_LEVEL+1];
    logic           rdy   [cbs_pkg::MAX_LEVEL+1];
    logic [cbs_pkg::MAX_LEVEL-1:0] active;

    // level register write and readback
    assign pready = 1'b1;
    assign prdata = {{(32-cbs_pkg::LEVEL_WIDTH){1'b0}}, r_level};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= cbs_pkg::LEVEL_RESET;
        end else if (psel && penable && pwrite && paddr == cbs_pkg::ADDR_LEVEL) begin
            r_level <= pwdata[cbs_pkg::LEVEL_WIDTH-1:0];
        end
    end

    // depth saturates at the chain length
    assign lvl = (r_level > cbs_pkg::LEVEL_WIDTH'(cbs_pkg::MAX_LEVEL))
               ? cbs_pkg::LEVEL_WIDTH'(cbs_pkg::MAX_LEVEL) : r_level;

    // curve request into the first cell
    assign busy = |active;
    always_comb begin
        flow[0].valid    = start && !busy;
        flow[0].last     = 1'b1;
        flow[0].curve.p0 = '{x: i_start_x, y: i_start_y, z: i_start_z};
        flow[0].curve.p1 = '{x: i_near_start_x, y: i_near_start_y, z: i_near_start_z};
        flow[0].curve.p2 = '{x: i_near_end_x, y: i_near_end_y, z: i_near_end_z};
        flow[0].curve.p3 = '{x: i_end_x, y: i_end_y, z: i_end_z};
    end

    // chain of cells, cell k splits only when k is below the level
    for (genvar k = 0; k < cbs_pkg::MAX_LEVEL; k++) begin : g_cell
        cbs_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_bypass (cbs_pkg::LEVEL_WIDTH'(k) >= lvl),
            .i_flow   (flow[k]),
            .o_ready  (rdy[k]),
            .o_flow   (flow[k+1]),
            .i_ready  (rdy[k+1]),
            .o_active (active[k])
        );
    end
    assign rdy[cbs_pkg::MAX_LEVEL] = 1'b1;

    // chord of the last cell's curve
    assign o_seg_valid    = flow[cbs_pkg::MAX_LEVEL].valid;
    assign o_last_segment = flow[cbs_pkg::MAX_LEVEL].last;
    assign o_seg_start_x  = flow[cbs_pkg::MAX_LEVEL].curve.p0.x;
    assign o_seg_start_y  = flow[cbs_pkg::MAX_LEVEL].curve.p0.y;
    assign o_seg_start_z  = flow[cbs_pkg::MAX_LEVEL].curve.p0.z;
    assign o_seg_end_x    = flow[cbs_pkg::MAX_LEVEL].curve.p3.x;
    assign o_seg_end_y    = flow[cbs_pkg::MAX_LEVEL].curve.p3.y;
    assign o_seg_end_z    = flow[cbs_pkg::MAX_LEVEL].curve.p3.z;
endmodule

>>> sv/cbs_checker.sv
// port-level checker for the bezier subdivider, bound to the top level
// depends on cubic_bezier_subdivider_assert.svh
`include "cubic_bezier_subdivider_assert.svh"
module cbs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_seg_valid,
    input logic o_last_segment
);
    // an accepted request makes the block busy
    `CBS_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    // no segment while idle
    `CBS_ASSERT_NOW(a_idle_quiet, !busy, !o_seg_valid)
    // the chain is empty after the last segment
    `CBS_ASSERT_NEXT(a_last_idle, o_seg_valid && o_last_segment, !busy)
endmodule

bind cubic_bezier_subdivider cbs_checker u_cbs_checker (.*);
